FILE: rtl/bdqs_pkg.sv
// shared constants, codes and result type of the bounded deque with search
package bdqs_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 7;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [POS_W-1:0]    position;
        logic [LEN_W-1:0]    length;
    } result_t;

endpackage

FILE: rtl/bdqs_cmd_if.sv
// command channel: operation and value words with valid/ready
interface bdqs_cmd_if;

    logic                                valid;
    logic                                ready;
    logic [bdqs_pkg::OP_W-1:0]           operation;
    logic signed [bdqs_pkg::VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);

endinterface

FILE: rtl/bdqs_rsp_if.sv
// response channel: status, find result and length words with valid/ready
interface bdqs_rsp_if;

    logic                            valid;
    logic                            ready;
    logic [bdqs_pkg::STATUS_W-1:0]   status;
    logic                            found;
    logic [bdqs_pkg::POS_W-1:0]      position;
    logic [bdqs_pkg::LEN_W-1:0]      length;

    modport source (output valid, output status, output found, output position,
                    output length, input ready);
    modport sink   (input valid, input status, input found, input position,
                    input length, output ready);

endinterface

FILE: rtl/bdqs_ram.sv
// ring storage: one write port, one read port with registered read data
module bdqs_ram #(
    parameter int DEPTH = bdqs_pkg::DEPTH_DEFAULT,
    localparam int IW = $clog2(DEPTH)
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [IW-1:0]                     waddr,
    input  logic [bdqs_pkg::VALUE_W-1:0]      wdata,
    input  logic                              re,
    input  logic [IW-1:0]                     raddr,
    output logic [bdqs_pkg::VALUE_W-1:0]      rdata
);

    logic [bdqs_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [bdqs_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bdqs_ctrl.sv
// sequencer: ring pointers, push/pop updates and the find walk over the ring
module bdqs_ctrl #(
    parameter int DEPTH = bdqs_pkg::DEPTH_DEFAULT,
    localparam int IW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bdqs_cmd_if.sink                      cmd,
    output bdqs_pkg::result_t             res,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          we,
    output logic [IW-1:0]                 waddr,
    output logic [bdqs_pkg::VALUE_W-1:0]  wdata,
    output logic                          re,
    output logic [IW-1:0]                 raddr,
    input  logic [bdqs_pkg::VALUE_W-1:0]  rdata
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SEARCH, S_REPORT} state_t;

    localparam logic [IW-1:0] LAST_SLOT  = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [IW:0]   RING_SIZE  = (IW + 1)'(DEPTH);

    state_t                        state_reg, state_next;
    logic [IW-1:0]                 front_reg, front_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic                          rd_valid_reg, rd_valid_next;
    logic [bdqs_pkg::OP_W-1:0]     op_reg, op_next;
    logic [bdqs_pkg::VALUE_W-1:0]  value_reg, value_next;
    bdqs_pkg::result_t             res_reg, res_next;
    logic [IW-1:0]                 slot_reg, slot_next;
    logic [CW-1:0]                 issue_reg, issue_next;
    logic [IW-1:0]                 rd_off_reg, rd_off_next;

    logic [IW-1:0]                 front_dec;
    logic [IW-1:0]                 front_inc;
    logic [IW-1:0]                 slot_inc;
    logic [IW:0]                   back_sum;
    logic [IW-1:0]                 back_slot;
    logic [CW-1:0]                 count_inc;
    logic [CW-1:0]                 count_dec;

    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - IW'(1);
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + IW'(1);
    assign slot_inc  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + IW'(1);
    // back slot is front + count, wrapped once; count is below DEPTH here
    assign back_sum  = (IW + 1)'(front_reg) + (IW + 1)'(IW'(count_reg));
    assign back_slot = (back_sum >= RING_SIZE) ? IW'(back_sum - RING_SIZE) : IW'(back_sum);
    assign count_inc = count_reg + CW'(1);
    assign count_dec = count_reg - CW'(1);

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        rd_valid_next = 1'b0;
        op_next       = op_reg;
        value_next    = value_reg;
        res_next      = res_reg;
        slot_next     = slot_reg;
        issue_next    = issue_reg;
        rd_off_next   = rd_off_reg;
        we            = 1'b0;
        waddr         = front_dec;
        wdata         = value_reg;
        re            = 1'b0;
        raddr         = slot_reg;
        cmd.ready     = (state_reg == S_IDLE);
        res_valid     = (state_reg == S_REPORT);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.operation;
                    value_next = cmd.value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next.status   = bdqs_pkg::STATUS_DONE;
                res_next.found    = 1'b0;
                res_next.position = '0;
                res_next.length   = bdqs_pkg::LEN_W'(count_reg);
                state_next        = S_REPORT;
                case (op_reg)
                    bdqs_pkg::OP_PUSH_FRONT:
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            res_next.status = bdqs_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            we              = 1'b1;
                            waddr           = front_dec;
                            front_next      = front_dec;
                            count_next      = count_inc;
                            res_next.length = bdqs_pkg::LEN_W'(count_inc);
                        end
                    end
                    bdqs_pkg::OP_PUSH_BACK:
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            res_next.status = bdqs_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            we              = 1'b1;
                            waddr           = back_slot;
                            count_next      = count_inc;
                            res_next.length = bdqs_pkg::LEN_W'(count_inc);
                        end
                    end
                    bdqs_pkg::OP_POP_FRONT:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = bdqs_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            front_next      = front_inc;
                            count_next      = count_dec;
                            res_next.length = bdqs_pkg::LEN_W'(count_dec);
                        end
                    end
                    bdqs_pkg::OP_POP_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = bdqs_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            count_next      = count_dec;
                            res_next.length = bdqs_pkg::LEN_W'(count_dec);
                        end
                    end
                    bdqs_pkg::OP_FIND:
                    begin
                        if (count_reg != '0)
                        begin
                            // first read goes out at the front slot
                            re            = 1'b1;
                            raddr         = front_reg;
                            rd_valid_next = 1'b1;
                            rd_off_next   = '0;
                            issue_next    = CW'(1);
                            slot_next     = front_inc;
                            state_next    = S_SEARCH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (rd_valid_reg && (rdata == value_reg))
                begin
                    res_next.found    = 1'b1;
                    res_next.position = bdqs_pkg::POS_W'(rd_off_reg);
                    state_next        = S_REPORT;
                end
                else if (rd_valid_reg && ((CW'(rd_off_reg) + CW'(1)) == count_reg))
                begin
                    state_next = S_REPORT;
                end
                else if (issue_reg < count_reg)
                begin
                    // keep one read in flight per cycle while comparing the last
                    re            = 1'b1;
                    raddr         = slot_reg;
                    rd_valid_next = 1'b1;
                    rd_off_next   = IW'(issue_reg);
                    issue_next    = issue_reg + CW'(1);
                    slot_next     = slot_inc;
                end
            end
            S_REPORT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        res_reg    <= res_next;
        slot_reg   <= slot_next;
        issue_reg  <= issue_next;
        rd_off_reg <= rd_off_next;
    end

    assign res = res_reg;

endmodule

FILE: rtl/bounded_deque_with_search_core.sv
// Bounded double-ended queue of signed 32-bit words with search, kept in a
// ring of DEPTH entries in one synchronous memory. One command is worked at
// a time: a push or pop goes from acceptance through an execute state to a
// report state, from which its result word enters the output register once
// that register is free, and a find walks the entries from the front until
// the first match (at most the current length), as the ring is read one
// entry per cycle through the single read port with registered read data.
// The output register lets the next command be accepted while the previous
// result still waits. Storage is not cleared at reset; only occupied entries
// are ever read.
module bounded_deque_with_search_core #(
    parameter int DEPTH = bdqs_pkg::DEPTH_DEFAULT,
    localparam int IW = $clog2(DEPTH)
) (
    input  logic        clk,
    input  logic        rst_n,
    bdqs_cmd_if.sink    cmd,
    bdqs_rsp_if.source  rsp
);

    bdqs_pkg::result_t            res;
    logic                         res_valid;
    logic                         res_ready;
    logic                         we;
    logic [IW-1:0]                waddr;
    logic [bdqs_pkg::VALUE_W-1:0] wdata;
    logic                         re;
    logic [IW-1:0]                raddr;
    logic [bdqs_pkg::VALUE_W-1:0] rdata;

    logic                         out_valid_reg, out_valid_next;
    bdqs_pkg::result_t            out_res_reg, out_res_next;

    bdqs_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    bdqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .re        (re),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    // output register is free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_res_reg.status;
    assign rsp.found    = out_res_reg.found;
    assign rsp.position = out_res_reg.position;
    assign rsp.length   = out_res_reg.length;

    a_one_cmd_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready
    ) else $error("command accepted while another is in progress");

    a_miss_has_no_position: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.found |-> rsp.position == '0
    ) else $error("position set on a result without a match");

    a_flagged_not_found: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == bdqs_pkg::STATUS_FULL ||
                      rsp.status == bdqs_pkg::STATUS_EMPTY) |-> !rsp.found
    ) else $error("full or empty status together with a match");

    a_result_lands: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> rsp.valid && rsp.length == $past(res.length)
    ) else $error("result word lost on the way to the output register");

endmodule

FILE: sim/tb.sv
// testbench for the bounded deque with search: directed, fill/drain, random and stall tests
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH = bdqs_pkg::DEPTH_DEFAULT;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam logic [bdqs_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;

    // burst flavors for random traffic
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_SEARCH = 2;
    localparam int MODE_MIXED  = 3;

    logic clk = 1'b0;
    logic rst_n;

    bdqs_cmd_if cmd_if ();
    bdqs_rsp_if rsp_if ();

    bounded_deque_with_search_core #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the deque
    logic [bdqs_pkg::VALUE_W-1:0] ring_mem [DEPTH];
    int                           head_slot;
    int                           held_count;

    bdqs_pkg::result_t pending_replies [$];
    int                error_count;
    logic              src_idle_en;
    logic              sink_idle_en;
    logic              long_hold;

    // mostly short pauses, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic bdqs_pkg::result_t apply_deque_op(
        input logic [bdqs_pkg::OP_W-1:0] op,
        input logic [bdqs_pkg::VALUE_W-1:0] val);
        bdqs_pkg::result_t r;
        r = '0;
        r.status = bdqs_pkg::STATUS_DONE;
        case (op)
            bdqs_pkg::OP_PUSH_FRONT:
                if (held_count >= DEPTH)
                    r.status = bdqs_pkg::STATUS_FULL;
                else
                begin
                    head_slot = (head_slot + DEPTH - 1) % DEPTH;
                    ring_mem[head_slot] = val;
                    held_count++;
                end
            bdqs_pkg::OP_PUSH_BACK:
                if (held_count >= DEPTH)
                    r.status = bdqs_pkg::STATUS_FULL;
                else
                begin
                    ring_mem[(head_slot + held_count) % DEPTH] = val;
                    held_count++;
                end
            bdqs_pkg::OP_POP_FRONT:
                if (held_count == 0)
                    r.status = bdqs_pkg::STATUS_EMPTY;
                else
                begin
                    head_slot = (head_slot + 1) % DEPTH;
                    held_count--;
                end
            bdqs_pkg::OP_POP_BACK:
                if (held_count == 0)
                    r.status = bdqs_pkg::STATUS_EMPTY;
                else
                    held_count--;
            bdqs_pkg::OP_FIND:
                for (int i = 0; i < held_count; i++)
                begin
                    if (ring_mem[(head_slot + i) % DEPTH] == val)
                    begin
                        r.found = 1'b1;
                        r.position = bdqs_pkg::POS_W'(i);
                        break;
                    end
                end
            default:
                ;
        endcase
        r.length = bdqs_pkg::LEN_W'(held_count);
        return r;
    endfunction

    function automatic logic [bdqs_pkg::OP_W-1:0] random_op(input int mode);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return OP_UNUSED_FIRST + bdqs_pkg::OP_W'($urandom_range(2));
        case (mode)
            MODE_GROW:
                if (roll < 70)
                    return $urandom_range(1) ? bdqs_pkg::OP_PUSH_FRONT : bdqs_pkg::OP_PUSH_BACK;
                else if (roll < 85)
                    return $urandom_range(1) ? bdqs_pkg::OP_POP_FRONT : bdqs_pkg::OP_POP_BACK;
            MODE_SHRINK:
                if (roll < 70)
                    return $urandom_range(1) ? bdqs_pkg::OP_POP_FRONT : bdqs_pkg::OP_POP_BACK;
                else if (roll < 85)
                    return $urandom_range(1) ? bdqs_pkg::OP_PUSH_FRONT : bdqs_pkg::OP_PUSH_BACK;
            MODE_SEARCH:
                if (roll < 20)
                    return $urandom_range(1) ? bdqs_pkg::OP_PUSH_FRONT : bdqs_pkg::OP_PUSH_BACK;
                else if (roll < 30)
                    return $urandom_range(1) ? bdqs_pkg::OP_POP_FRONT : bdqs_pkg::OP_POP_BACK;
            default:
                if (roll < 40)
                    return $urandom_range(1) ? bdqs_pkg::OP_PUSH_FRONT : bdqs_pkg::OP_PUSH_BACK;
                else if (roll < 70)
                    return $urandom_range(1) ? bdqs_pkg::OP_POP_FRONT : bdqs_pkg::OP_POP_BACK;
        endcase
        return bdqs_pkg::OP_FIND;
    endfunction

    // held values give hits, a small pool gives duplicates
    function automatic logic [bdqs_pkg::VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40 && held_count > 0)
            return ring_mem[(head_slot + $urandom_range(held_count - 1)) % DEPTH];
        if (roll < 65)
            return bdqs_pkg::VALUE_W'(int'($urandom_range(8)) - 4);
        return $urandom();
    endfunction

    // called just after a rising edge; leaves valid high after acceptance
    task automatic send_word(input logic [bdqs_pkg::OP_W-1:0] op,
                             input logic [bdqs_pkg::VALUE_W-1:0] val);
        if (src_idle_en && $urandom_range(99) < 25)
        begin
            cmd_if.valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.operation <= op;
        cmd_if.value     <= val;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        pending_replies.push_back(apply_deque_op(op, val));
    endtask

    task automatic test_directed();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_word(bdqs_pkg::OP_POP_FRONT, 32'h0000_0000);
        send_word(bdqs_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
        send_word(bdqs_pkg::OP_FIND, 32'h0000_0000);
        send_word(OP_UNUSED_FIRST, 32'h1234_5678);
        send_word(OP_UNUSED_FIRST + 3'd1, 32'hFFFF_FFFF);
        send_word(OP_UNUSED_FIRST + 3'd2, 32'h0000_0000);
        send_word(bdqs_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_word(bdqs_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_word(bdqs_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_word(bdqs_pkg::OP_PUSH_BACK, 32'h0000_0000);
        send_word(bdqs_pkg::OP_FIND, 32'h7FFF_FFFF);
        send_word(bdqs_pkg::OP_FIND, 32'h8000_0000);
        send_word(bdqs_pkg::OP_FIND, 32'hFFFF_FFFF);
        send_word(bdqs_pkg::OP_FIND, 32'h0001_E240);
        // duplicate: first match wins, then moves once the front one goes
        send_word(bdqs_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_word(bdqs_pkg::OP_FIND, 32'hFFFF_FFFF);
        send_word(bdqs_pkg::OP_POP_FRONT, 32'h5555_5555);
        send_word(bdqs_pkg::OP_FIND, 32'hFFFF_FFFF);
        send_word(bdqs_pkg::OP_POP_BACK, 32'hAAAA_AAAA);
        send_word(bdqs_pkg::OP_POP_FRONT, 32'h0000_0000);
        send_word(bdqs_pkg::OP_POP_BACK, 32'h0000_0000);
        send_word(bdqs_pkg::OP_POP_FRONT, 32'h0000_0000);
        send_word(bdqs_pkg::OP_POP_BACK, 32'h0000_0000);
        send_word(bdqs_pkg::OP_FIND, 32'h8000_0000);
    endtask

    task automatic test_fill_and_drain();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        while (held_count < DEPTH)
            send_word($urandom_range(1) ? bdqs_pkg::OP_PUSH_FRONT : bdqs_pkg::OP_PUSH_BACK,
                      $urandom());
        send_word(bdqs_pkg::OP_PUSH_FRONT, $urandom());
        send_word(bdqs_pkg::OP_PUSH_BACK, $urandom());
        send_word(bdqs_pkg::OP_FIND, ring_mem[head_slot]);
        send_word(bdqs_pkg::OP_FIND, ring_mem[(head_slot + DEPTH - 1) % DEPTH]);
        send_word(bdqs_pkg::OP_FIND, pick_value());
        send_word(bdqs_pkg::OP_PUSH_BACK, $urandom());
        while (held_count > 0)
        begin
            if ($urandom_range(9) == 0)
                send_word(bdqs_pkg::OP_FIND, pick_value());
            else
                send_word($urandom_range(1) ? bdqs_pkg::OP_POP_FRONT : bdqs_pkg::OP_POP_BACK,
                          $urandom());
        end
        send_word(bdqs_pkg::OP_POP_BACK, $urandom());
        send_word(bdqs_pkg::OP_POP_FRONT, $urandom());
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int mode;
        int burst;
        sent = 0;
        while (sent < n_items)
        begin
            mode  = $urandom_range(MODE_MIXED);
            burst = $urandom_range(40, 10);
            src_idle_en  = ($urandom_range(3) != 0);
            sink_idle_en = ($urandom_range(3) != 0);
            repeat (burst)
                send_word(random_op(mode), pick_value());
            sent += burst;
        end
    endtask

    task automatic test_output_stall();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        long_hold    = 1'b1;
        repeat (40)
            send_word(random_op(MODE_MIXED), pick_value());
        sink_idle_en = 1'b1;
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (sink_idle_en && $urandom_range(99) < 30)
            begin
                rsp_if.ready <= 1'b0;
                repeat (idle_len() - 1) @(posedge clk);
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_replies
        bdqs_pkg::result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result word with none outstanding");
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp_if.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", want.status, rsp_if.status);
                    error_count++;
                end
                if (rsp_if.found !== want.found)
                begin
                    $error("found mismatch: expected %0d, got %0d", want.found, rsp_if.found);
                    error_count++;
                end
                if (rsp_if.position !== want.position)
                begin
                    $error("position mismatch: expected %0d, got %0d",
                           want.position, rsp_if.position);
                    error_count++;
                end
                if (rsp_if.length !== want.length)
                begin
                    $error("length mismatch: expected %0d, got %0d", want.length, rsp_if.length);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        error_count  = 0;
        head_slot    = 0;
        held_count   = 0;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        long_hold    = 1'b0;
        rst_n            <= 1'b0;
        cmd_if.valid     <= 1'b0;
        cmd_if.operation <= bdqs_pkg::OP_PUSH_FRONT;
        cmd_if.value     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_drain();
        test_random_traffic(560);
        test_output_stall();

        cmd_if.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_replies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
